[rtl/ittc_emergency_brake_assert.svh]
// Assertion macros for the emergency brake block, compiled out under synthesis.
`ifndef ITTC_EMERGENCY_BRAKE_ASSERT_SVH
`define ITTC_EMERGENCY_BRAKE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while reset is released.
`define ITTC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("ittc_emergency_brake: assertion failed");

// Checked at every edge, reset included.
`define ITTC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ittc_emergency_brake: assertion failed");

`else

`define ITTC_ASSERT(lbl, clk, rstn, prop)
`define ITTC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/ittc_pkg.sv]
// Types, constants and the cosine contents shared by the emergency brake modules.
`default_nettype none

package ittc_pkg;

    // Cosine quarter-wave store.
    localparam int COS_TABLE_DEPTH = 1024;
    localparam int COS_ADDR_W      = $clog2(COS_TABLE_DEPTH);
    localparam int COS_IDX_W       = COS_ADDR_W + 1;
    localparam int COS_DATA_W      = 16;
    localparam int SERIES_TERMS    = 14;

    // Datapath widths.
    localparam int ANGLE_W    = 20;
    localparam int COS_X_W    = 17;
    localparam int COS_VAL_W  = 17;
    localparam int COS_FRAC_W = 15;
    localparam int RATE_W     = 17;
    localparam int LHS_W      = 26;
    localparam int RHS_W      = 30;
    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    // Angles in Q16 radians.
    localparam logic signed [ANGLE_W-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [ANGLE_W-1:0] TWO_PI_Q16  = 20'sd411775;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [63:0]               HALF_PI_Q30 = 64'd1686629713;

    // Index = floor(x * depth / (pi/2)) is taken exactly as (x * COS_RECIP) >> RECIP_SHIFT:
    // the reciprocal is rounded up and the shift is wide enough that the error stays
    // below one part in pi/2 for every folded angle.
    localparam int          RECIP_SHIFT = 34;
    localparam logic [63:0] COS_RECIP   =
        ((64'd1 << RECIP_SHIFT) * 64'(COS_TABLE_DEPTH) + 64'(HALF_PI_Q16) - 64'd1)
        / 64'(HALF_PI_Q16);

    localparam logic signed [MUL_B_W-1:0] RANGE_SCALE = 32'sd1000;
    localparam logic [13:0]               TTC_RESET   = 14'd500;

    typedef struct packed {
        logic [15:0] beam_range;
        logic        range_valid;
        logic        scan_end;
    } t_in_item;

    typedef struct packed {
        logic        brake;
        logic [15:0] closest_range;
        logic        closest_found;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] vehicle_speed;
        logic signed [18:0] start_angle;
        logic [15:0]        angle_step;
        logic [13:0]        ttc_threshold;
    } t_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VEHICLE_SPEED = 2'd0,
        CFG_START_ANGLE   = 2'd1,
        CFG_ANGLE_STEP    = 2'd2,
        CFG_TTC_THRESHOLD = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                  we;
        logic [COS_ADDR_W-1:0] addr;
        logic [COS_DATA_W-1:0] data;
    } t_ram_wr;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_ANGLE,
        ST_FOLD,
        ST_IDX,
        ST_LOOK,
        ST_COS,
        ST_RATE,
        ST_LHS,
        ST_TEST,
        ST_EMIT
    } t_state;

    typedef logic [COS_DATA_W-1:0] t_cos_rom [COS_TABLE_DEPTH];

    // Unsigned restoring division, used only while the table contents are elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
            rem = {rem[63:0], num[bit_pos]};
            if (rem >= {1'b0, den}) begin
                rem          = rem - {1'b0, den};
                quo[bit_pos] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q30 Taylor series of cos(x), rounded half up to Q1.15 and clamped.
    function automatic logic [COS_DATA_W-1:0] series_cos(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        divisor;
        logic signed [63:0] acc;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        acc  = $signed(term);
        for (int k = 0; k < SERIES_TERMS; k++) begin
            divisor = 64'((2 * k + 1) * (2 * k + 2));
            term    = (term * x2) >> 30;
            term    = udiv64(term, divisor);
            if ((k & 1) != 0) begin
                acc = acc + $signed(term);
            end else begin
                acc = acc - $signed(term);
            end
        end
        if (acc < 64'sd0) begin
            acc = 64'sd0;
        end
        acc = (acc + 64'sd16384) >>> 15;
        if (acc > 64'sd32767) begin
            acc = 64'sd32767;
        end
        return acc[COS_DATA_W-1:0];
    endfunction

    function automatic t_cos_rom cos_rom_build();
        t_cos_rom rom;
        for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
            rom[i] = series_cos(udiv64(HALF_PI_Q30 * 64'(i), 64'(COS_TABLE_DEPTH)));
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = cos_rom_build();

endpackage

`default_nettype wire

[rtl/ittc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ittc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/ittc_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none

module ittc_mul (
    input  wire logic                                 i_clk,
    input  wire ittc_pkg::t_mul_req                   i_req,
    output logic signed [ittc_pkg::PROD_W-1:0]        o_prod
);

    logic signed [ittc_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= ittc_pkg::PROD_W'(i_req.a) * ittc_pkg::PROD_W'(i_req.b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[rtl/ittc_core.sv]
// Sequencer and per-scan state of the emergency brake: table fill and beam evaluation.
`default_nettype none
`include "ittc_emergency_brake_assert.svh"

module ittc_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire ittc_pkg::t_cfg                         i_cfg,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire ittc_pkg::t_in_item                     i_in_item,
    output logic                                        o_res_valid,
    input  wire logic                                   i_res_ready,
    output ittc_pkg::t_out_item                         o_res_item,
    output ittc_pkg::t_mul_req                          o_mul_req,
    input  wire logic signed [ittc_pkg::PROD_W-1:0]     i_mul_prod,
    output ittc_pkg::t_ram_wr                           o_ram_wr,
    output logic [ittc_pkg::COS_ADDR_W-1:0]             o_ram_raddr,
    input  wire logic [ittc_pkg::COS_DATA_W-1:0]        i_ram_rdata
);

    ittc_pkg::t_state                          r_state,      n_state;
    logic [ittc_pkg::COS_ADDR_W-1:0]           r_fill,       n_fill;
    ittc_pkg::t_in_item                        r_item,       n_item;
    logic                                      r_first,      n_first;
    logic signed [ittc_pkg::ANGLE_W-1:0]       r_beam_angle, n_beam_angle;
    logic [ittc_pkg::COS_X_W-1:0]              r_x,          n_x;
    logic                                      r_neg,        n_neg;
    logic                                      r_in_range,   n_in_range;
    logic signed [ittc_pkg::RATE_W-1:0]        r_rate,       n_rate;
    logic [ittc_pkg::LHS_W-1:0]                r_lhs,        n_lhs;
    logic [15:0]                               r_min,        n_min;
    logic                                      r_any,        n_any;
    logic                                      r_brake,      n_brake;

    logic signed [ittc_pkg::ANGLE_W-1:0]       angle_sum;
    logic signed [ittc_pkg::ANGLE_W-1:0]       angle_hi;
    logic signed [ittc_pkg::ANGLE_W-1:0]       angle_wrapped;
    logic signed [ittc_pkg::ANGLE_W-1:0]       angle_mag;
    logic                                      fold_neg;
    logic signed [ittc_pkg::ANGLE_W-1:0]       fold_x;
    logic [ittc_pkg::COS_IDX_W-1:0]            cos_idx;
    logic signed [ittc_pkg::COS_VAL_W-1:0]     cos_mag;
    logic signed [ittc_pkg::COS_VAL_W-1:0]     cos_val;
    logic                                      beam_hit;

    // Angle of this beam, wrapped back into [-pi, pi].
    assign angle_sum = r_first ? ittc_pkg::ANGLE_W'(i_cfg.start_angle)
                               : r_beam_angle + $signed(ittc_pkg::ANGLE_W'(i_cfg.angle_step));
    assign angle_hi = (angle_sum > ittc_pkg::PI_Q16) ? angle_sum - ittc_pkg::TWO_PI_Q16
                                                     : angle_sum;
    assign angle_wrapped = (angle_hi < -ittc_pkg::PI_Q16) ? angle_hi + ittc_pkg::TWO_PI_Q16
                                                          : angle_hi;

    // Fold onto the first quadrant; the second quadrant mirrors with a negated cosine.
    assign angle_mag = (r_beam_angle < 0) ? -r_beam_angle : r_beam_angle;
    assign fold_neg  = angle_mag > ittc_pkg::HALF_PI_Q16;
    assign fold_x    = fold_neg ? ittc_pkg::PI_Q16 - angle_mag : angle_mag;

    assign cos_idx = i_mul_prod[ittc_pkg::RECIP_SHIFT +: ittc_pkg::COS_IDX_W];
    assign cos_mag = $signed({1'b0, i_ram_rdata});
    assign cos_val = !r_in_range ? '0 : (r_neg ? -cos_mag : cos_mag);

    // Range over rate below threshold, written as range * 1000 < threshold * rate.
    assign beam_hit = r_item.range_valid && (r_rate > 0) &&
                      (ittc_pkg::RHS_W'(r_lhs) < i_mul_prod[ittc_pkg::RHS_W-1:0]);

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_item       = r_item;
        n_first      = r_first;
        n_beam_angle = r_beam_angle;
        n_x          = r_x;
        n_neg        = r_neg;
        n_in_range   = r_in_range;
        n_rate       = r_rate;
        n_lhs        = r_lhs;
        n_min        = r_min;
        n_any        = r_any;
        n_brake      = r_brake;
        o_in_stall   = 1'b1;
        o_res_valid  = 1'b0;
        o_res_item   = '0;
        o_mul_req    = '0;
        o_ram_wr     = '0;
        o_ram_raddr  = '0;

        unique case (r_state)
            ittc_pkg::ST_FILL: begin
                o_ram_wr.we   = 1'b1;
                o_ram_wr.addr = r_fill;
                o_ram_wr.data = ittc_pkg::COS_ROM[r_fill];
                n_fill        = r_fill + 1'b1;
                if (r_fill == ittc_pkg::COS_ADDR_W'(ittc_pkg::COS_TABLE_DEPTH - 1)) begin
                    n_state = ittc_pkg::ST_IDLE;
                end
            end
            ittc_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = ittc_pkg::ST_ANGLE;
                end
            end
            ittc_pkg::ST_ANGLE: begin
                n_beam_angle = angle_wrapped;
                n_first      = 1'b0;
                n_state      = ittc_pkg::ST_FOLD;
            end
            ittc_pkg::ST_FOLD: begin
                n_x     = fold_x[ittc_pkg::COS_X_W-1:0];
                n_neg   = fold_neg;
                n_state = ittc_pkg::ST_IDX;
            end
            ittc_pkg::ST_IDX: begin
                o_mul_req.a = $signed(ittc_pkg::MUL_A_W'(r_x));
                o_mul_req.b = $signed(ittc_pkg::MUL_B_W'(ittc_pkg::COS_RECIP));
                n_state     = ittc_pkg::ST_LOOK;
            end
            ittc_pkg::ST_LOOK: begin
                o_ram_raddr = cos_idx[ittc_pkg::COS_ADDR_W-1:0];
                n_in_range  = cos_idx < ittc_pkg::COS_IDX_W'(ittc_pkg::COS_TABLE_DEPTH);
                n_state     = ittc_pkg::ST_COS;
            end
            ittc_pkg::ST_COS: begin
                o_mul_req.a = ittc_pkg::MUL_A_W'(cos_val);
                o_mul_req.b = ittc_pkg::MUL_B_W'(i_cfg.vehicle_speed);
                n_state     = ittc_pkg::ST_RATE;
            end
            ittc_pkg::ST_RATE: begin
                // Arithmetic shift floors toward minus infinity, as the rate needs.
                n_rate      = $signed(i_mul_prod[ittc_pkg::COS_FRAC_W +: ittc_pkg::RATE_W]);
                o_mul_req.a = $signed(ittc_pkg::MUL_A_W'(r_item.beam_range));
                o_mul_req.b = ittc_pkg::RANGE_SCALE;
                n_state     = ittc_pkg::ST_LHS;
            end
            ittc_pkg::ST_LHS: begin
                n_lhs       = i_mul_prod[ittc_pkg::LHS_W-1:0];
                o_mul_req.a = $signed(ittc_pkg::MUL_A_W'(i_cfg.ttc_threshold));
                o_mul_req.b = ittc_pkg::MUL_B_W'(r_rate);
                n_state     = ittc_pkg::ST_TEST;
            end
            ittc_pkg::ST_TEST: begin
                if (r_item.range_valid) begin
                    n_any = 1'b1;
                    if (r_item.beam_range < r_min) begin
                        n_min = r_item.beam_range;
                    end
                end
                if (beam_hit) begin
                    n_brake = 1'b1;
                end
                n_state = r_item.scan_end ? ittc_pkg::ST_EMIT : ittc_pkg::ST_IDLE;
            end
            ittc_pkg::ST_EMIT: begin
                if (i_res_ready) begin
                    o_res_valid              = 1'b1;
                    o_res_item.brake         = r_brake;
                    o_res_item.closest_range = r_min;
                    o_res_item.closest_found = r_any;
                    n_first      = 1'b1;
                    n_beam_angle = '0;
                    n_min        = '1;
                    n_any        = 1'b0;
                    n_brake      = 1'b0;
                    n_state      = ittc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ittc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ittc_pkg::ST_FILL;
            r_fill       <= '0;
            r_first      <= 1'b1;
            r_beam_angle <= '0;
            r_min        <= '1;
            r_any        <= 1'b0;
            r_brake      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_first      <= n_first;
            r_beam_angle <= n_beam_angle;
            r_min        <= n_min;
            r_any        <= n_any;
            r_brake      <= n_brake;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_x        <= n_x;
        r_neg      <= n_neg;
        r_in_range <= n_in_range;
        r_rate     <= n_rate;
        r_lhs      <= n_lhs;
    end

    `ITTC_ASSERT(a_angle_in_range, i_clk, i_rst_n, (r_beam_angle <= ittc_pkg::PI_Q16) && (r_beam_angle >= -ittc_pkg::PI_Q16))
    `ITTC_ASSERT(a_fold_quadrant, i_clk, i_rst_n, (r_state == ittc_pkg::ST_IDX) |-> (r_x <= ittc_pkg::COS_X_W'(ittc_pkg::HALF_PI_Q16)))
    `ITTC_ASSERT(a_brake_needs_valid, i_clk, i_rst_n, r_brake |-> r_any)
    `ITTC_ASSERT(a_clear_after_result, i_clk, i_rst_n, o_res_valid |=> (r_first && !r_any && !r_brake && (r_min == '1)))
    `ITTC_ASSERT(a_accept_starts_beam, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> (r_state == ittc_pkg::ST_ANGLE))

endmodule

`default_nettype wire

[rtl/ittc_emergency_brake.sv]
// Each beam passes through ANGLE, FOLD, IDX, LOOK, COS, RATE, LHS and TEST before the
// next one can be accepted; the beam that ends a scan also passes through EMIT, which
// waits until the output register is free and then places the result item there.
// One shared multiplier serves the table index, closing rate and both test products.
// After reset the cosine store is filled with all COS_TABLE_DEPTH (1024) entries while input
// is stalled; configuration writes are taken at any time and reset to their defaults.
`default_nettype none

module ittc_emergency_brake (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [ittc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [ittc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire ittc_pkg::t_in_item                    i_in_item,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output ittc_pkg::t_out_item                        o_out_item
);

    ittc_pkg::t_cfg        r_cfg, n_cfg;
    logic                  r_out_valid, n_out_valid;
    ittc_pkg::t_out_item   r_out_item, n_out_item;

    logic                                   res_valid;
    logic                                   res_ready;
    ittc_pkg::t_out_item                    res_item;
    ittc_pkg::t_mul_req                     mul_req;
    logic signed [ittc_pkg::PROD_W-1:0]     mul_prod;
    ittc_pkg::t_ram_wr                      ram_wr;
    logic [ittc_pkg::COS_ADDR_W-1:0]        ram_raddr;
    logic [ittc_pkg::COS_DATA_W-1:0]        ram_rdata;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (ittc_pkg::t_cfg_idx'(i_cfg_index))
                ittc_pkg::CFG_VEHICLE_SPEED: n_cfg.vehicle_speed = $signed(i_cfg_data[15:0]);
                ittc_pkg::CFG_START_ANGLE:   n_cfg.start_angle   = $signed(i_cfg_data[18:0]);
                ittc_pkg::CFG_ANGLE_STEP:    n_cfg.angle_step    = i_cfg_data[15:0];
                ittc_pkg::CFG_TTC_THRESHOLD: n_cfg.ttc_threshold = i_cfg_data[13:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    // The output register frees the sequencer as soon as the item is handed over.
    assign res_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        if (res_valid) begin
            n_out_valid = 1'b1;
            n_out_item  = res_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vehicle_speed <= '0;
            r_cfg.start_angle   <= '0;
            r_cfg.angle_step    <= '0;
            r_cfg.ttc_threshold <= ittc_pkg::TTC_RESET;
            r_out_valid         <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    ittc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_item  (res_item),
        .o_mul_req   (mul_req),
        .i_mul_prod  (mul_prod),
        .o_ram_wr    (ram_wr),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    ittc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    ittc_ram #(
        .WIDTH (ittc_pkg::COS_DATA_W),
        .DEPTH (ittc_pkg::COS_TABLE_DEPTH)
    ) u_cos_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the lidar time-to-collision emergency brake.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = ittc_pkg::COS_TABLE_DEPTH;
    localparam int Q16_PI = 205887;
    localparam int Q16_TWO_PI = 411775;
    localparam int Q16_HALF_PI = 102944;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES = 10;
    localparam int PHASE_BEAMS = 175;

    typedef enum {ROW_BEAM, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        ittc_pkg::t_cfg_idx  reg_idx;
        int                  value;
        ittc_pkg::t_in_item  beam;
        bit                  typed;
        ittc_pkg::t_out_item want;
    } t_plan_row;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    ittc_pkg::t_cfg_idx              cfg_index = ittc_pkg::CFG_VEHICLE_SPEED;
    logic [ittc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    ittc_pkg::t_in_item              in_item = '0;
    logic                            in_stall;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    ittc_pkg::t_out_item             out_item;

    // Shadow copy of the registers and the per-scan state.
    logic [15:0] cos_quarter [TABLE_DEPTH];
    int          cfg_speed = 0;
    int          cfg_start = 0;
    int          cfg_step = 0;
    int          cfg_thr = 500;
    int          scan_angle;
    bit          scan_first;
    logic [15:0] scan_min;
    bit          scan_any;
    bit          scan_brake;

    ittc_pkg::t_out_item verdicts_due [$];
    t_plan_row           plan [$];

    int errors = 0;
    int beams_sent = 0;
    int verdicts_seen = 0;
    int brake_count = 0;
    int blind_count = 0;
    int settings_used = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    ittc_emergency_brake dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #5 clk = ~clk;

    // Q30 Taylor series of the cosine, rounded half up to Q1.15 and clamped.
    function automatic logic [15:0] taylor_cos_q15(input longint unsigned x);
        longint unsigned sq;
        longint unsigned t;
        longint unsigned div;
        longint          s;
        sq = (x * x) >> 30;
        t = 64'd1 << 30;
        s = longint'(t);
        for (int n = 1; n <= 14; n++) begin
            div = (2 * n - 1) * (2 * n);
            t = ((t * sq) >> 30) / div;
            if (n % 2 == 1) begin
                s = s - longint'(t);
            end else begin
                s = s + longint'(t);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        s = (s + 16384) / 32768;
        if (s > 32767) begin
            s = 32767;
        end
        return s[15:0];
    endfunction

    function automatic int wrap_pi(input int a);
        if (a > Q16_PI) begin
            a -= Q16_TWO_PI;
        end
        if (a < -Q16_PI) begin
            a += Q16_TWO_PI;
        end
        return a;
    endfunction

    function automatic int quarter_cos(input int x);
        int slot;
        slot = (x * TABLE_DEPTH) / Q16_HALF_PI;
        return (slot >= TABLE_DEPTH) ? 0 : int'(cos_quarter[slot]);
    endfunction

    function automatic int cos_of_angle(input int a);
        int m;
        m = (a < 0) ? -a : a;
        if (m > Q16_PI) begin
            m = Q16_PI;
        end
        if (m > Q16_HALF_PI) begin
            return -quarter_cos(Q16_PI - m);
        end
        return quarter_cos(m);
    endfunction

    function automatic void reset_scan();
        scan_angle = 0;
        scan_first = 1'b1;
        scan_min = 16'hFFFF;
        scan_any = 1'b0;
        scan_brake = 1'b0;
    endfunction

    // Advances the shadow state by one beam; returns 1 when the beam closes a scan.
    function automatic bit assess_beam(input ittc_pkg::t_in_item b,
                                       output ittc_pkg::t_out_item v);
        longint closing;
        v = '0;
        scan_angle = scan_first ? wrap_pi(cfg_start) : wrap_pi(scan_angle + cfg_step);
        scan_first = 1'b0;
        // Arithmetic shift floors toward minus infinity.
        closing = (longint'(cfg_speed) * cos_of_angle(scan_angle)) >>> 15;
        if (b.range_valid) begin
            scan_any = 1'b1;
            if (b.beam_range < scan_min) begin
                scan_min = b.beam_range;
            end
            if (closing >= 1 &&
                longint'(b.beam_range) * 1000 < longint'(cfg_thr) * closing) begin
                scan_brake = 1'b1;
            end
        end
        if (!b.scan_end) begin
            return 1'b0;
        end
        v.brake = scan_brake;
        v.closest_range = scan_min;
        v.closest_found = scan_any;
        reset_scan();
        return 1'b1;
    endfunction

    function automatic t_plan_row beam_row(input int mm, input bit valid, input bit last,
                                           input bit typed = 1'b0, input bit w_brake = 1'b0,
                                           input int w_closest = 0, input bit w_found = 1'b0);
        t_plan_row r;
        r.kind = ROW_BEAM;
        r.reg_idx = ittc_pkg::CFG_VEHICLE_SPEED;
        r.value = 0;
        r.beam.beam_range = mm[15:0];
        r.beam.range_valid = valid;
        r.beam.scan_end = last;
        r.typed = typed;
        r.want.brake = w_brake;
        r.want.closest_range = w_closest[15:0];
        r.want.closest_found = w_found;
        return r;
    endfunction

    function automatic t_plan_row write_row(input ittc_pkg::t_cfg_idx idx, input int value);
        t_plan_row r;
        r = beam_row(0, 1'b0, 1'b0);
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.value = value;
        return r;
    endfunction

    function automatic void plan_add(input t_plan_row r);
        plan = {plan, r};
    endfunction

    task automatic write_reg(input ittc_pkg::t_cfg_idx idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[ittc_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ittc_pkg::CFG_VEHICLE_SPEED: cfg_speed = int'($signed(value[15:0]));
            ittc_pkg::CFG_START_ANGLE:   cfg_start = int'($signed(value[18:0]));
            ittc_pkg::CFG_ANGLE_STEP:    cfg_step = int'(value[15:0]);
            ittc_pkg::CFG_TTC_THRESHOLD: cfg_thr = int'(value[13:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_beam(input ittc_pkg::t_in_item b, input bit typed,
                             input ittc_pkg::t_out_item want);
        ittc_pkg::t_out_item pv;
        ittc_pkg::t_out_item due;
        while (idle_on && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= b;
        do @(posedge clk); while (in_stall);
        beams_sent++;
        if (assess_beam(b, pv)) begin
            due = typed ? want : pv;
            verdicts_due = {verdicts_due, due};
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= idle_on && ($urandom_range(99) < 6);
        end
    end

    always @(posedge clk) begin
        ittc_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: result item with none expected: got brake=%0b closest=%0d found=%0b",
                         $time, out_item.brake, out_item.closest_range, out_item.closest_found);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                verdicts_seen++;
                if (out_item.brake !== want.brake ||
                    out_item.closest_range !== want.closest_range ||
                    out_item.closest_found !== want.closest_found) begin
                    $display("%0t: mismatch: expected brake=%0b closest=%0d found=%0b, %s",
                             $time, want.brake, want.closest_range, want.closest_found,
                             $sformatf("got brake=%0b closest=%0d found=%0b", out_item.brake,
                                       out_item.closest_range, out_item.closest_found));
                    errors++;
                end
                brake_count += want.brake;
                blind_count += !want.closest_found;
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int pick;
        int n;
        int target;
        bit dense;
        ittc_pkg::t_in_item b;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            cos_quarter[i] = taylor_cos_q15(Q30_HALF_PI * i / TABLE_DEPTH);
        end
        reset_scan();

        // Directed rows: defaults after reset, field extremes, the brake boundary,
        // zero threshold, receding and slow vehicles, and angle wrap both ways.
        plan_add(beam_row(0, 1, 1, 1, 0, 0, 1));
        plan_add(beam_row(65535, 0, 1, 1, 0, 65535, 0));
        plan_add(beam_row(65535, 1, 1, 1, 0, 65535, 1));
        plan_add(beam_row(1234, 1, 0));
        plan_add(beam_row(77, 0, 0));
        plan_add(beam_row(500, 1, 1, 1, 0, 500, 1));
        plan_add(write_row(ittc_pkg::CFG_VEHICLE_SPEED, 32767));
        plan_add(write_row(ittc_pkg::CFG_TTC_THRESHOLD, 10000));
        plan_add(beam_row(65535, 1, 1, 1, 1, 65535, 1));
        plan_add(beam_row(0, 1, 0));
        plan_add(beam_row(9, 0, 1, 1, 1, 0, 1));
        plan_add(write_row(ittc_pkg::CFG_TTC_THRESHOLD, 1000));
        plan_add(beam_row(32766, 1, 1, 1, 0, 32766, 1));
        plan_add(beam_row(32765, 1, 1, 1, 1, 32765, 1));
        plan_add(write_row(ittc_pkg::CFG_TTC_THRESHOLD, 0));
        plan_add(beam_row(0, 1, 1, 1, 0, 0, 1));
        plan_add(write_row(ittc_pkg::CFG_VEHICLE_SPEED, -32768));
        plan_add(write_row(ittc_pkg::CFG_TTC_THRESHOLD, 10000));
        plan_add(beam_row(0, 1, 1, 1, 0, 0, 1));
        plan_add(write_row(ittc_pkg::CFG_START_ANGLE, Q16_PI));
        plan_add(beam_row(100, 1, 1));
        plan_add(write_row(ittc_pkg::CFG_START_ANGLE, -262144));
        plan_add(write_row(ittc_pkg::CFG_ANGLE_STEP, 65535));
        plan_add(beam_row(20, 1, 0));
        plan_add(beam_row(3000, 1, 0));
        plan_add(beam_row(65535, 1, 0));
        plan_add(beam_row(5, 0, 0));
        plan_add(beam_row(1, 1, 0));
        plan_add(beam_row(40000, 1, 1));
        plan_add(write_row(ittc_pkg::CFG_VEHICLE_SPEED, 1));
        plan_add(write_row(ittc_pkg::CFG_START_ANGLE, 262143));
        plan_add(write_row(ittc_pkg::CFG_ANGLE_STEP, 0));
        plan_add(beam_row(0, 1, 1, 1, 0, 0, 1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                quiesce();
                write_reg(plan[i].reg_idx, plan[i].value);
            end else begin
                send_beam(plan[i].beam, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce();
            pick = $urandom_range(99);
            write_reg(ittc_pkg::CFG_VEHICLE_SPEED,
                      pick < 15 ? 32767 : pick < 25 ? -32768 : pick < 35 ? 0 :
                      pick < 45 ? $urandom_range(400) - 200 : $urandom_range(65535));
            pick = $urandom_range(99);
            write_reg(ittc_pkg::CFG_START_ANGLE,
                      pick < 10 ? Q16_PI : pick < 20 ? -Q16_PI : pick < 25 ? 262143 :
                      pick < 30 ? -262144 : $urandom_range(524287) - 262144);
            pick = $urandom_range(99);
            write_reg(ittc_pkg::CFG_ANGLE_STEP,
                      pick < 20 ? 0 : pick < 30 ? 65535 :
                      pick < 70 ? $urandom_range(3000) : $urandom_range(65535));
            pick = $urandom_range(99);
            write_reg(ittc_pkg::CFG_TTC_THRESHOLD,
                      (ph == 1 || pick < 5) ? 16383 : pick < 15 ? 0 : pick < 25 ? 10000 :
                      $urandom_range(10000, 1));
            settings_used++;
            // One phase runs without any idling; another starts with a long hold-off
            // at the result side so the block backs up into its input.
            idle_on = (ph != 4);
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            target = beams_sent + PHASE_BEAMS;
            while (beams_sent < target) begin
                pick = $urandom_range(99);
                n = pick < 70 ? $urandom_range(8, 1) :
                    pick < 95 ? $urandom_range(30, 9) : $urandom_range(80, 31);
                dense = ($urandom_range(9) != 0);
                for (int k = 0; k < n; k++) begin
                    pick = $urandom_range(99);
                    b.beam_range = pick < 40 ? 16'($urandom) :
                                   pick < 85 ? 16'($urandom_range(3000)) :
                                   (pick[0] ? 16'hFFFF : 16'h0000);
                    b.range_valid = dense ? ($urandom_range(99) < 80) : ($urandom_range(99) < 5);
                    b.scan_end = (k == n - 1);
                    send_beam(b, 1'b0, '0);
                end
            end
        end

        in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Run covered %0d beams and %0d scan results over %0d random register settings.",
                 beams_sent, verdicts_seen, settings_used);
        $display("%0d scans requested braking and %0d scans had no valid beam.",
                 brake_count, blind_count);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
